// ===== sv/assert_macros.svh =====
// Assertion macros shared by the estimator RTL.
// Each macro checks on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled at the clock and disabled during reset.
`define FOW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose property is checked in the cycle after its trigger.
`define FOW_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

// ===== sv/fec_ow_pkg.sv =====
// Package of the FEC overhead window estimator: field widths, codes and
// divider interface types. No dependencies.
package fec_ow_pkg;

	localparam int MAX_COLUMNS_DEF  = 32;
	localparam int WINDOW_DEPTH_DEF = 64;
	localparam int ACC_W            = 32;
	localparam int RATIO_W          = 20;
	localparam int BYTES_W          = 16;
	localparam int COLUMN_W         = 5;
	localparam int CCOUNT_W         = 6;
	localparam int WLIMIT_W         = 7;
	localparam int WCOUNT_W         = 7;
	localparam int CFG_DATA_W       = 7;
	localparam int MIN_FOR_ESTIMATE = 5;
	localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

	typedef enum logic [1:0] {
		FUNC_SOURCE = 2'd0,
		FUNC_REPAIR = 2'd1,
		FUNC_BLOCK  = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic {
		CFG_COLUMN_COUNT = 1'b0,
		CFG_WINDOW_LIMIT = 1'b1
	} cfg_idx_t;

	// Quotient = ({hi, lo}) / divisor, where hi is known to be below divisor.
	typedef struct packed {
		logic               start;
		logic [ACC_W-1:0]   hi;
		logic [RATIO_W-1:0] lo;
		logic [ACC_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [RATIO_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== sv/fec_ow_event_if.sv =====
// Channel interfaces of the estimator: input events and result items.
// Depends on fec_ow_pkg for the field widths.
interface fec_ow_event_if import fec_ow_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic [BYTES_W-1:0]  packet_bytes;
	logic [COLUMN_W-1:0] column;

	modport source (output valid, func, packet_bytes, column, input ready);
	modport sink (input valid, func, packet_bytes, column, output ready);
endinterface

interface fec_ow_result_if import fec_ow_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [RATIO_W-1:0]  estimate;
	logic                estimate_valid;
	logic [WCOUNT_W-1:0] window_count;

	modport source (output valid, estimate, estimate_valid, window_count, input ready);
	modport sink (input valid, estimate, estimate_valid, window_count, output ready);
endinterface

// ===== sv/fec_overhead_window_estimator_unit.sv =====
// FEC overhead window estimator, top level.
// Uses fec_ow_pkg, the channel interfaces, fec_ow_ram and fec_ow_div.
//
// Usage:
// - event_ch carries one item per packet event (func, packet_bytes, column);
//   result_ch returns exactly one item per event with the window mean,
//   its valid flag and the number of ratios held.
// - The configuration port takes column_count (index 0) and window_limit
//   (index 1); write it only while the block is idle (not enforced by the
//   block); a column_count write clears the per-column byte accumulators.
// - Events are handled one at a time. A source or repair packet passes
//   through a read-modify-write of the accumulator memory before its
//   result; clear all goes straight to its result.
// - A block-complete event walks the active columns: per column a read,
//   a check, a division on the shared divider unless the ratio is zero or
//   saturates, and a ring push that first drops the oldest ratio when the
//   ring is full; then a check plus a drop for each ratio trimmed, and
//   the mean division when the window holds enough ratios.
// - Reset empties the window and marks all accumulators as zero at once;
//   no clearing pass is needed.
// - A waiting result is held in the output register; the next event is taken
//   meanwhile and only its result waits until the receiver accepts.
`include "assert_macros.svh"

module fec_overhead_window_estimator_unit import fec_ow_pkg::*; #(
	parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fec_ow_event_if.sink          event_ch,
	fec_ow_result_if.source       result_ch
);
	localparam int AW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int NCW    = ($clog2(MAX_COLUMNS + 1) > CCOUNT_W) ? $clog2(MAX_COLUMNS + 1)
		: CCOUNT_W;
	localparam int HW     = $clog2(WINDOW_DEPTH);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int LW     = (CNT_W > WLIMIT_W) ? CNT_W : WLIMIT_W;
	localparam int SUM_W  = RATIO_W + CNT_W;
	localparam logic [NCW-1:0]   N_MAX   = NCW'(MAX_COLUMNS);
	localparam logic [LW-1:0]    L_MAX   = LW'(WINDOW_DEPTH);
	localparam logic [CNT_W-1:0] C_FULL  = CNT_W'(WINDOW_DEPTH);
	localparam logic [CNT_W-1:0] C_MIN   = CNT_W'(MIN_FOR_ESTIMATE);
	localparam logic [HW-1:0]    H_LAST  = HW'(WINDOW_DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_PKT, S_BC_RD, S_BC_CHK, S_BC_DIV, S_PUSH_CHK, S_PUSH_DROP,
		S_PUSH_WR, S_TRIM_CHK, S_TRIM_DROP, S_MEAN, S_MEAN_DIV, S_EMIT
	} state_t;

	state_t                state_q;
	logic [CCOUNT_W-1:0]   column_count_q;
	logic [WLIMIT_W-1:0]   window_limit_q;
	logic [MAX_COLUMNS-1:0] acc_vld_q;
	logic [1:0]            func_q;
	logic [BYTES_W-1:0]    bytes_q;
	logic [AW-1:0]         addr_q;
	logic                  col_ok_q;
	logic [AW-1:0]         k_q;
	logic [RATIO_W-1:0]    ratio_q;
	logic [HW-1:0]         head_q;
	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      sum_q;
	logic [RATIO_W-1:0]    mean_q;
	logic                  out_valid_q;
	logic [RATIO_W-1:0]    out_est_q;
	logic                  out_est_vld_q;
	logic [WCOUNT_W-1:0]   out_count_q;

	logic [NCW-1:0]        n_act;
	logic [LW-1:0]         l_act;
	logic [NCW-1:0]        col_ext;
	logic                  take;
	logic                  is_pkt;
	logic                  col_ok;
	logic [AW-1:0]         col_addr;
	logic                  acc_re, acc_we;
	logic [AW-1:0]         acc_raddr;
	logic [2*ACC_W-1:0]    acc_rdata, acc_cur, acc_wdata;
	logic [ACC_W-1:0]      acc_src, acc_rep, acc_sel;
	logic [ACC_W:0]        acc_sum;
	logic [ACC_W-1:0]      acc_new;
	logic                  ring_re, ring_we;
	logic [HW-1:0]         ring_raddr, oldest, head_inc;
	logic [RATIO_W-1:0]    ring_rdata;
	logic [CNT_W:0]        old_calc;
	logic                  ring_full, over_lim, last_col, emit_go;
	logic [LW-1:0]         count_ext;
	logic [LW-1:0]         count_wide;
	logic                  sat_ratio;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	// Effective register values after range limiting.
	assign n_act = (column_count_q == '0) ? NCW'(1)
		: (NCW'(column_count_q) > N_MAX) ? N_MAX : NCW'(column_count_q);
	assign l_act = (window_limit_q == '0) ? LW'(1)
		: (LW'(window_limit_q) > L_MAX) ? L_MAX : LW'(window_limit_q);

	assign event_ch.ready = (state_q == S_IDLE);
	assign take     = event_ch.valid && event_ch.ready;
	assign is_pkt   = (event_ch.func == FUNC_SOURCE) || (event_ch.func == FUNC_REPAIR);
	assign col_ext  = NCW'(event_ch.column);
	assign col_ok   = (n_act == NCW'(1)) || (col_ext < n_act);
	assign col_addr = (n_act == NCW'(1)) ? '0 : col_ext[AW-1:0];

	// Accumulator memory: source count in the low half, repair count in the high half.
	assign acc_re    = (take && is_pkt) || (state_q == S_BC_RD);
	assign acc_raddr = (state_q == S_IDLE) ? col_addr : k_q;
	assign acc_cur   = acc_vld_q[(state_q == S_PKT) ? addr_q : k_q] ? acc_rdata : '0;
	assign acc_src   = acc_cur[ACC_W-1:0];
	assign acc_rep   = acc_cur[2*ACC_W-1:ACC_W];
	assign acc_sel   = (func_q == FUNC_SOURCE) ? acc_src : acc_rep;
	assign acc_sum   = {1'b0, acc_sel} + (ACC_W+1)'(bytes_q);
	assign acc_new   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
	assign acc_wdata = (func_q == FUNC_SOURCE) ? {acc_rep, acc_new} : {acc_new, acc_src};
	assign acc_we    = (state_q == S_PKT) && col_ok_q;

	fec_ow_ram #(.WIDTH(2*ACC_W), .DEPTH(MAX_COLUMNS), .AW(AW)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (addr_q),
		.wdata (acc_wdata),
		.re    (acc_re),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	// Ring addressing; the depth need not be a power of two.
	assign old_calc   = ({1'b0, CNT_W'(head_q)} >= {1'b0, count_q})
		? ({1'b0, CNT_W'(head_q)} - {1'b0, count_q})
		: ({1'b0, CNT_W'(head_q)} + {1'b0, C_FULL} - {1'b0, count_q});
	assign oldest     = old_calc[HW-1:0];
	assign head_inc   = (head_q == H_LAST) ? '0 : head_q + 1'b1;
	assign ring_full  = (count_q == C_FULL);
	assign count_wide = LW'(count_q);
	assign count_ext  = count_wide;
	assign over_lim   = count_ext > l_act;
	assign ring_re    = ((state_q == S_PUSH_CHK) && ring_full)
		|| ((state_q == S_TRIM_CHK) && over_lim);
	assign ring_raddr = (state_q == S_PUSH_CHK) ? head_q : oldest;
	assign ring_we    = (state_q == S_PUSH_WR);
	assign last_col   = (NCW'(k_q) == n_act - NCW'(1));

	fec_ow_ram #(.WIDTH(RATIO_W), .DEPTH(WINDOW_DEPTH), .AW(HW)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (head_q),
		.wdata (ratio_q),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// A ratio of 16 or more saturates; below that the quotient fits 20 bits.
	assign sat_ratio = {4'b0, acc_rep} >= {acc_src, 4'b0};

	always_comb begin
		div_req = '0;
		if (state_q == S_BC_CHK && acc_src != '0 && !sat_ratio) begin
			div_req.start   = 1'b1;
			div_req.hi      = {4'b0, acc_rep[ACC_W-1:4]};
			div_req.lo      = {acc_rep[3:0], {(RATIO_W-4){1'b0}}};
			div_req.divisor = acc_src;
		end else if (state_q == S_MEAN && count_q >= C_MIN) begin
			div_req.start   = 1'b1;
			div_req.hi      = ACC_W'(sum_q >> RATIO_W);
			div_req.lo      = sum_q[RATIO_W-1:0];
			div_req.divisor = ACC_W'(count_q);
		end
	end

	fec_ow_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign emit_go = !out_valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			column_count_q <= CCOUNT_W'(1);
			window_limit_q <= WLIMIT_W'(16);
			acc_vld_q      <= '0;
			head_q         <= '0;
			count_q        <= '0;
			sum_q          <= '0;
			mean_q         <= '0;
			out_valid_q    <= 1'b0;
			k_q            <= '0;
		end else begin
			if (out_valid_q && result_ch.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_COLUMN_COUNT: begin
						column_count_q <= cfg_data[CCOUNT_W-1:0];
						acc_vld_q      <= '0;
					end
					CFG_WINDOW_LIMIT: window_limit_q <= cfg_data[WLIMIT_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (func_t'(event_ch.func))
							FUNC_SOURCE, FUNC_REPAIR: state_q <= S_PKT;
							FUNC_BLOCK: begin
								k_q     <= '0;
								state_q <= S_BC_RD;
							end
							FUNC_CLEAR: begin
								head_q    <= '0;
								count_q   <= '0;
								sum_q     <= '0;
								mean_q    <= '0;
								acc_vld_q <= '0;
								state_q   <= S_EMIT;
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_PKT: begin
					if (col_ok_q) begin
						acc_vld_q[addr_q] <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_BC_RD: state_q <= S_BC_CHK;
				S_BC_CHK: begin
					if (div_req.start) begin
						state_q <= S_BC_DIV;
					end else begin
						state_q <= S_PUSH_CHK;
					end
				end
				S_BC_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_PUSH_CHK;
					end
				end
				S_PUSH_CHK: state_q <= ring_full ? S_PUSH_DROP : S_PUSH_WR;
				S_PUSH_DROP: begin
					sum_q   <= sum_q - SUM_W'(ring_rdata);
					count_q <= count_q - 1'b1;
					state_q <= S_PUSH_WR;
				end
				S_PUSH_WR: begin
					head_q  <= head_inc;
					sum_q   <= sum_q + SUM_W'(ratio_q);
					count_q <= count_q + 1'b1;
					if (last_col) begin
						acc_vld_q <= '0;
						state_q   <= S_TRIM_CHK;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_BC_RD;
					end
				end
				S_TRIM_CHK: state_q <= over_lim ? S_TRIM_DROP : S_MEAN;
				S_TRIM_DROP: begin
					sum_q   <= sum_q - SUM_W'(ring_rdata);
					count_q <= count_q - 1'b1;
					state_q <= S_TRIM_CHK;
				end
				S_MEAN: begin
					if (div_req.start) begin
						state_q <= S_MEAN_DIV;
					end else begin
						mean_q  <= '0;
						state_q <= S_EMIT;
					end
				end
				S_MEAN_DIV: begin
					if (div_rsp.done) begin
						mean_q  <= div_rsp.quot;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (out_valid_q && result_ch.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload and result payload registers.
	always_ff @(posedge clk) begin
		if (take) begin
			func_q   <= event_ch.func;
			bytes_q  <= event_ch.packet_bytes;
			addr_q   <= col_addr;
			col_ok_q <= col_ok;
		end
		if (state_q == S_BC_CHK) begin
			ratio_q <= (acc_src == '0) ? '0 : RATIO_MAX;
		end
		if (state_q == S_BC_DIV && div_rsp.done) begin
			ratio_q <= div_rsp.quot;
		end
		if (state_q == S_EMIT && emit_go) begin
			out_est_vld_q <= count_q >= C_MIN;
			out_est_q     <= (count_q >= C_MIN) ? mean_q : '0;
			out_count_q   <= count_ext[WCOUNT_W-1:0];
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.estimate       = out_est_q;
	assign result_ch.estimate_valid = out_est_vld_q;
	assign result_ch.window_count   = out_count_q;

	`FOW_ASSERT(a_count_bound, count_q <= C_FULL, "window count beyond ring depth")
	`FOW_ASSERT(a_push_has_room, !ring_we || (count_q < C_FULL), "ring written while full")
	`FOW_ASSERT(a_div_free, !div_req.start || !div_rsp.busy, "divider started while busy")
endmodule

// ===== sv/fec_ow_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fec_ow_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/fec_ow_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 20-bit quotient.
// Depends on fec_ow_pkg for the request and response types.
`include "assert_macros.svh"

module fec_ow_div import fec_ow_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int STEP_W = $clog2(RATIO_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATIO_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [ACC_W-1:0]   rem_q;
	logic [RATIO_W-1:0] lo_q;
	logic [ACC_W-1:0]   div_q;
	logic [RATIO_W-1:0] quot_q;
	logic [ACC_W:0]     shifted;
	logic               fits;

	assign shifted = {rem_q, lo_q[RATIO_W-1]};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.hi;
			lo_q   <= req.lo;
			div_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? ACC_W'(shifted - {1'b0, div_q}) : shifted[ACC_W-1:0];
			lo_q   <= {lo_q[RATIO_W-2:0], 1'b0};
			quot_q <= {quot_q[RATIO_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	`FOW_ASSERT_NEXT(a_div_start_busy, req.start, busy_q, "divider did not start")
	`FOW_ASSERT_NEXT(a_div_last_done, busy_q && !req.start && step_q == LAST_STEP, done_q, "divider did not finish")
endmodule
